// ----- sv/beam_transport_poly_map_core_macros.svh -----
// Assertion macros for the beam transport map checker.
// Used by bt_checker only; expects i_clk and i_rst_n in scope.
`ifndef BEAM_TRANSPORT_POLY_MAP_CORE_MACROS_SVH
`define BEAM_TRANSPORT_POLY_MAP_CORE_MACROS_SVH
// Same-cycle implication, quiet while reset is held
`define BT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("beam transport port check failed");
// Next-cycle implication, live during reset
`define BT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("beam transport port check failed");
`endif

// ----- sv/bt_pkg.sv -----
// Shared types, constants and arithmetic helpers of the beam transport map.
// No dependencies; imported by every module of the block.
package bt_pkg;

    localparam int HORIZ_TERMS = 31;
    localparam int VERT_TERMS  = 8;
    localparam int COEF_WIDTH  = 40;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_WIDTH   = 5;

    // mm to metres: floor((-x * 8192 + 500) / 1000) = floor((1024 * a + 62) / 125),
    // a = -x. Clamp a where the result saturates anyway, offset the numerator
    // positive and divide by 125 with a 41-bit reciprocal (2^47 / 125) in two 20-bit halves.
    localparam int NUM_WIDTH   = 40;
    localparam int NUM_HALF    = 20;
    localparam int RECIP_WIDTH = 41;
    localparam int RECIP_SHIFT = 47;
    localparam int PPROD_WIDTH = NUM_HALF + RECIP_WIDTH;
    localparam int RPROD_WIDTH = NUM_WIDTH + RECIP_WIDTH;
    localparam int MM_SHIFT    = 10;
    localparam logic [RECIP_WIDTH-1:0]      RECIP    = 41'd1125899906843;
    localparam logic signed [DATA_WIDTH:0]  A_HI     = 33'sd262144000;
    localparam logic signed [DATA_WIDTH:0]  A_LO     = -33'sd262144001;
    localparam logic signed [NUM_WIDTH:0]   N_OFFSET = 41'sd536870912062;
    localparam logic signed [65:0]          Q_OFFSET = 66'sd4294967296;

    // Monomial tables: base 0 x, 1 u, 2 d, 3 y, 4 v
    localparam int BASE_VARS = 5;
    localparam int B_X = 0;
    localparam int B_U = 1;
    localparam int B_D = 2;
    localparam int B_Y = 3;
    localparam int B_V = 4;
    localparam int L1_TERMS = 15;
    localparam int L2_TERMS = 19;
    localparam int L1_A [L1_TERMS] = '{0, 0, 0, 1, 1, 2, 3, 3, 4, 0, 0, 1, 1, 2, 2};
    localparam int L1_B [L1_TERMS] = '{0, 1, 2, 1, 2, 2, 3, 4, 4, 3, 4, 3, 4, 3, 4};
    localparam int L2_SQ [L2_TERMS] =
        '{0, 0, 0, 1, 1, 2, 9, 9, 10, 3, 3, 4, 11, 11, 12, 5, 13, 13, 14};
    localparam int L2_BV [L2_TERMS] =
        '{0, 1, 2, 1, 2, 2, 3, 4, 4, 1, 2, 2, 3, 4, 4, 2, 3, 4, 4};

    // Dot product widths
    localparam int PROD_WIDTH  = COEF_WIDTH + DATA_WIDTH;
    localparam int CPROD_WIDTH = PROD_WIDTH - 24;
    localparam int SUM_WIDTH   = 56;
    localparam int CLAMP_WIDTH = 42;
    localparam int GROUP       = 4;
    localparam int X_GROUPS    = (HORIZ_TERMS + GROUP - 1) / GROUP;
    localparam int X_PAD       = X_GROUPS * GROUP;
    localparam int X_GROUPS2   = X_GROUPS / GROUP;
    localparam int V_GROUPS    = VERT_TERMS / GROUP;
    localparam logic [IDX_WIDTH-1:0] H_LIMIT = IDX_WIDTH'(HORIZ_TERMS);
    localparam logic [IDX_WIDTH-1:0] V_LIMIT = IDX_WIDTH'(VERT_TERMS);

    // Metre scaling, monomials, dot product
    localparam int PIPE_LATENCY = 3 + 4 + 5;

    typedef enum logic {OP_LOAD, OP_TRANSPORT} t_op;
    typedef enum logic [1:0] {TBL_X, TBL_U, TBL_Y, TBL_V} t_tbl;

    typedef struct packed {
        logic                 valid;
        logic                 load;
        t_tbl                 sel;
        logic [IDX_WIDTH-1:0] idx;
    } t_ctl;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    function automatic t_word f_sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic t_word f_neg_sat(input t_word a);
        return (a == 32'sh80000000) ? 32'sh7fffffff : -a;
    endfunction

    // Negated, clamped, scaled by 1024 and offset numerator, positive for every input
    function automatic logic [NUM_WIDTH-1:0] f_num(input t_word a);
        logic signed [DATA_WIDTH:0] ng;
        logic signed [NUM_WIDTH:0]  w;
        ng = -{a[DATA_WIDTH-1], a};
        if (ng > A_HI) ng = A_HI;
        else if (ng < A_LO) ng = A_LO;
        w = ((NUM_WIDTH+1)'(ng) <<< MM_SHIFT) + N_OFFSET;
        return w[NUM_WIDTH-1:0];
    endfunction

    // Join the two reciprocal halves, drop the offset and saturate
    function automatic t_word f_quot(input logic [PPROD_WIDTH-1:0] ph,
                                     input logic [PPROD_WIDTH-1:0] pl);
        logic [RPROD_WIDTH-1:0] p;
        logic signed [65:0]     q;
        p = (RPROD_WIDTH'(ph) << NUM_HALF) + RPROD_WIDTH'(pl);
        q = $signed(66'(p[RPROD_WIDTH-1:RECIP_SHIFT])) - Q_OFFSET;
        return f_sat32(q);
    endfunction

    // Q2.29 product back to Q2.29, rounded and saturated
    function automatic t_word f_qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd268435456) >>> 29;
        return f_sat32({{2{s[63]}}, s});
    endfunction

    // Q15.24 by Q2.29 product to 29 fraction bits, rounded
    function automatic logic signed [CPROD_WIDTH-1:0] f_cround(
        input logic signed [PROD_WIDTH-1:0] p);
        logic signed [PROD_WIDTH-1:0] s;
        s = (p + 72'sd8388608) >>> 24;
        return s[CPROD_WIDTH-1:0];
    endfunction

endpackage

// ----- sv/bt_metres.sv -----
// Input stage of the beam transport map: negation and mm-to-metre scaling.
// Depends on bt_pkg; division by 1000 is a reciprocal multiplication over three stages.
module bt_metres import bt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl                         i_ctl,
    input  logic signed [COEF_WIDTH-1:0] i_coef,
    input  t_word                        i_x,
    input  t_word                        i_y,
    input  t_word                        i_u,
    input  t_word                        i_v,
    input  t_word                        i_d,
    output t_ctl                         o_ctl,
    output logic signed [COEF_WIDTH-1:0] o_coef,
    output t_word                        o_x,
    output t_word                        o_y,
    output t_word                        o_u,
    output t_word                        o_v,
    output t_word                        o_d
);

    t_ctl                         r_ctl  [0:1];
    logic signed [COEF_WIDTH-1:0] r_coef [0:1];
    logic [NUM_WIDTH-1:0]         r_num_x, r_num_y;
    logic [PPROD_WIDTH-1:0]       r_ph_x, r_pl_x, r_ph_y, r_pl_y;
    t_word                        r_u [0:1];
    t_word                        r_v [0:1];
    t_word                        r_d [0:1];
    t_ctl                         r_out_ctl;
    logic signed [COEF_WIDTH-1:0] r_out_coef;
    t_word                        r_out_x, r_out_y, r_out_u, r_out_v, r_out_d;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0]  <= '0;
            r_ctl[1]  <= '0;
            r_out_ctl <= '0;
        end else begin
            r_ctl[0]  <= i_ctl;
            r_ctl[1]  <= r_ctl[0];
            r_out_ctl <= r_ctl[1];
        end
    end

    // Form the numerators, multiply both halves by the reciprocal, take the quotient
    always_ff @(posedge i_clk) begin
        r_coef[0]  <= i_coef;
        r_num_x    <= f_num(i_x);
        r_num_y    <= f_num(i_y);
        r_u[0]     <= f_neg_sat(i_u);
        r_v[0]     <= f_neg_sat(i_v);
        r_d[0]     <= i_d;
        r_coef[1]  <= r_coef[0];
        r_ph_x     <= PPROD_WIDTH'(r_num_x[NUM_WIDTH-1:NUM_HALF]) * PPROD_WIDTH'(RECIP);
        r_pl_x     <= PPROD_WIDTH'(r_num_x[NUM_HALF-1:0]) * PPROD_WIDTH'(RECIP);
        r_ph_y     <= PPROD_WIDTH'(r_num_y[NUM_WIDTH-1:NUM_HALF]) * PPROD_WIDTH'(RECIP);
        r_pl_y     <= PPROD_WIDTH'(r_num_y[NUM_HALF-1:0]) * PPROD_WIDTH'(RECIP);
        r_u[1]     <= r_u[0];
        r_v[1]     <= r_v[0];
        r_d[1]     <= r_d[0];
        r_out_coef <= r_coef[1];
        r_out_x    <= f_quot(r_ph_x, r_pl_x);
        r_out_y    <= f_quot(r_ph_y, r_pl_y);
        r_out_u    <= r_u[1];
        r_out_v    <= r_v[1];
        r_out_d    <= r_d[1];
    end

    assign o_ctl  = r_out_ctl;
    assign o_coef = r_out_coef;
    assign o_x    = r_out_x;
    assign o_y    = r_out_y;
    assign o_u    = r_out_u;
    assign o_v    = r_out_v;
    assign o_d    = r_out_d;

endmodule

// ----- sv/bt_mono.sv -----
// Monomial builder: quadratic then cubic products of the track, four stages.
// Depends on bt_pkg for the term tables and rounding helpers.
module bt_mono import bt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl                         i_ctl,
    input  logic signed [COEF_WIDTH-1:0] i_coef,
    input  t_word                        i_x,
    input  t_word                        i_y,
    input  t_word                        i_u,
    input  t_word                        i_v,
    input  t_word                        i_d,
    output t_ctl                         o_ctl,
    output logic signed [COEF_WIDTH-1:0] o_coef,
    output t_word                        o_h [HORIZ_TERMS],
    output t_word                        o_t [VERT_TERMS]
);

    t_word                        w_base [BASE_VARS];
    t_ctl                         r_ctl  [1:4];
    logic signed [COEF_WIDTH-1:0] r_coef [1:4];
    logic signed [63:0]           r_p1 [L1_TERMS];
    t_word                        r_q1 [L1_TERMS];
    t_word                        r_q1_3 [L1_TERMS];
    logic signed [63:0]           r_p2 [L2_TERMS];
    t_word                        r_b1 [BASE_VARS];
    t_word                        r_b2 [BASE_VARS];
    t_word                        r_b3 [BASE_VARS];
    t_word                        r_h [HORIZ_TERMS];
    t_word                        r_t [VERT_TERMS];
    t_word                        n_h [HORIZ_TERMS];
    t_word                        n_t [VERT_TERMS];

    assign w_base[B_X] = i_x;
    assign w_base[B_U] = i_u;
    assign w_base[B_D] = i_d;
    assign w_base[B_Y] = i_y;
    assign w_base[B_V] = i_v;

    // Gather the term vectors for the last stage
    always_comb begin
        n_h[0] = r_b3[B_X];
        n_h[1] = r_b3[B_U];
        n_h[2] = r_b3[B_D];
        for (int k = 0; k < 9; k++) n_h[3+k] = r_q1_3[k];
        for (int k = 0; k < L2_TERMS; k++) n_h[12+k] = f_qround(r_p2[k]);
        n_t[0] = r_b3[B_Y];
        n_t[1] = r_b3[B_V];
        n_t[2] = r_q1_3[9];
        n_t[3] = r_q1_3[11];
        n_t[4] = r_q1_3[13];
        n_t[5] = r_q1_3[10];
        n_t[6] = r_q1_3[12];
        n_t[7] = r_q1_3[14];
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 4; s++) r_ctl[s] <= '0;
        end else begin
            r_ctl[1] <= i_ctl;
            for (int s = 2; s <= 4; s++) r_ctl[s] <= r_ctl[s-1];
        end
    end

    // Multiply, round, multiply, round
    always_ff @(posedge i_clk) begin
        r_coef[1] <= i_coef;
        for (int s = 2; s <= 4; s++) r_coef[s] <= r_coef[s-1];
        for (int k = 0; k < L1_TERMS; k++) begin
            r_p1[k]   <= 64'(w_base[L1_A[k]]) * 64'(w_base[L1_B[k]]);
            r_q1[k]   <= f_qround(r_p1[k]);
            r_q1_3[k] <= r_q1[k];
        end
        for (int k = 0; k < L2_TERMS; k++) begin
            r_p2[k] <= 64'(r_q1[L2_SQ[k]]) * 64'(r_b2[L2_BV[k]]);
        end
        for (int k = 0; k < BASE_VARS; k++) begin
            r_b1[k] <= w_base[k];
            r_b2[k] <= r_b1[k];
            r_b3[k] <= r_b2[k];
        end
        for (int k = 0; k < HORIZ_TERMS; k++) r_h[k] <= n_h[k];
        for (int k = 0; k < VERT_TERMS; k++) r_t[k] <= n_t[k];
    end

    assign o_ctl  = r_ctl[4];
    assign o_coef = r_coef[4];
    assign o_h    = r_h;
    assign o_t    = r_t;

endmodule

// ----- sv/bt_dot.sv -----
// Coefficient tables, dot products, adder tree and output scaling.
// Depends on bt_pkg; loads are written here so they stay in item order.
module bt_dot import bt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl                         i_ctl,
    input  logic signed [COEF_WIDTH-1:0] i_coef,
    input  t_word                        i_h [HORIZ_TERMS],
    input  t_word                        i_t [VERT_TERMS],
    output logic                         o_valid,
    output t_word                        o_x,
    output t_word                        o_y,
    output t_word                        o_u,
    output t_word                        o_v
);

    logic signed [COEF_WIDTH-1:0]  r_cx [HORIZ_TERMS];
    logic signed [COEF_WIDTH-1:0]  r_cu [HORIZ_TERMS];
    logic signed [COEF_WIDTH-1:0]  r_cy [VERT_TERMS];
    logic signed [COEF_WIDTH-1:0]  r_cv [VERT_TERMS];
    logic                          r_vld [1:5];
    logic signed [PROD_WIDTH-1:0]  r_px [X_PAD];
    logic signed [PROD_WIDTH-1:0]  r_pu [X_PAD];
    logic signed [PROD_WIDTH-1:0]  r_py [VERT_TERMS];
    logic signed [PROD_WIDTH-1:0]  r_pv [VERT_TERMS];
    logic signed [SUM_WIDTH-1:0]   r_gx [X_GROUPS];
    logic signed [SUM_WIDTH-1:0]   r_gu [X_GROUPS];
    logic signed [SUM_WIDTH-1:0]   r_gy [V_GROUPS];
    logic signed [SUM_WIDTH-1:0]   r_gv [V_GROUPS];
    logic signed [SUM_WIDTH-1:0]   n_gx [X_GROUPS];
    logic signed [SUM_WIDTH-1:0]   n_gu [X_GROUPS];
    logic signed [SUM_WIDTH-1:0]   n_gy [V_GROUPS];
    logic signed [SUM_WIDTH-1:0]   n_gv [V_GROUPS];
    logic signed [SUM_WIDTH-1:0]   r_hx [X_GROUPS2];
    logic signed [SUM_WIDTH-1:0]   r_hu [X_GROUPS2];
    logic signed [SUM_WIDTH-1:0]   r_sy, r_sv;
    logic signed [SUM_WIDTH-1:0]   n_sx, n_su;
    logic signed [CLAMP_WIDTH-1:0] r_cl_x, r_cl_y;
    logic signed [CLAMP_WIDTH-1:0] n_cl_x, n_cl_y;
    t_word                         r_u4, r_v4;
    t_word                         r_out_x, r_out_y, r_out_u, r_out_v;
    logic                          n_wr;

    function automatic logic signed [CLAMP_WIDTH-1:0] f_clamp(
        input logic signed [SUM_WIDTH-1:0] sum);
        logic signed [SUM_WIDTH-1:0] s;
        logic signed [SUM_WIDTH-1:0] lim;
        lim = SUM_WIDTH'(64'sd1 <<< 40);
        s   = -sum;
        if (s > lim) s = lim;
        else if (s < -lim) s = -lim;
        return s[CLAMP_WIDTH-1:0];
    endfunction

    // Metres back to mm: times 1000, round away 13 bits
    function automatic t_word f_to_mm(input logic signed [CLAMP_WIDTH-1:0] s);
        logic signed [65:0] m;
        m = 66'(s);
        m = (m <<< 10) - (m <<< 4) - (m <<< 3) + 66'sd4096;
        return f_sat32(m >>> 13);
    endfunction

    assign n_wr = i_ctl.valid && i_ctl.load;

    // Write one coefficient; out-of-range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HORIZ_TERMS; i++) begin
                r_cx[i] <= '0;
                r_cu[i] <= '0;
            end
            for (int i = 0; i < VERT_TERMS; i++) begin
                r_cy[i] <= '0;
                r_cv[i] <= '0;
            end
        end else if (n_wr) begin
            case (i_ctl.sel)
                TBL_X: if (i_ctl.idx < H_LIMIT) r_cx[i_ctl.idx] <= i_coef;
                TBL_U: if (i_ctl.idx < H_LIMIT) r_cu[i_ctl.idx] <= i_coef;
                TBL_Y: if (i_ctl.idx < V_LIMIT) r_cy[i_ctl.idx[2:0]] <= i_coef;
                TBL_V: if (i_ctl.idx < V_LIMIT) r_cv[i_ctl.idx[2:0]] <= i_coef;
                default: ;
            endcase
        end
    end

    // Round the products, sum in groups of four, finish the x and u sums, clamp x and y
    always_comb begin
        for (int g = 0; g < X_GROUPS; g++) begin
            n_gx[g] = '0;
            n_gu[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                n_gx[g] = n_gx[g] + SUM_WIDTH'(f_cround(r_px[GROUP*g+k]));
                n_gu[g] = n_gu[g] + SUM_WIDTH'(f_cround(r_pu[GROUP*g+k]));
            end
        end
        for (int g = 0; g < V_GROUPS; g++) begin
            n_gy[g] = '0;
            n_gv[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                n_gy[g] = n_gy[g] + SUM_WIDTH'(f_cround(r_py[GROUP*g+k]));
                n_gv[g] = n_gv[g] + SUM_WIDTH'(f_cround(r_pv[GROUP*g+k]));
            end
        end
        n_sx = '0;
        n_su = '0;
        for (int g = 0; g < X_GROUPS2; g++) begin
            n_sx = n_sx + r_hx[g];
            n_su = n_su + r_hu[g];
        end
        n_cl_x = f_clamp(n_sx);
        n_cl_y = f_clamp(r_sy);
    end

    // Advance the result strobe; loads drop here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 5; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[1] <= i_ctl.valid && !i_ctl.load;
            for (int s = 2; s <= 5; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Products, tree levels and output scaling
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HORIZ_TERMS; i++) begin
            r_px[i] <= PROD_WIDTH'(r_cx[i]) * PROD_WIDTH'(i_h[i]);
            r_pu[i] <= PROD_WIDTH'(r_cu[i]) * PROD_WIDTH'(i_h[i]);
        end
        for (int i = HORIZ_TERMS; i < X_PAD; i++) begin
            r_px[i] <= '0;
            r_pu[i] <= '0;
        end
        for (int i = 0; i < VERT_TERMS; i++) begin
            r_py[i] <= PROD_WIDTH'(r_cy[i]) * PROD_WIDTH'(i_t[i]);
            r_pv[i] <= PROD_WIDTH'(r_cv[i]) * PROD_WIDTH'(i_t[i]);
        end
        r_gx <= n_gx;
        r_gu <= n_gu;
        r_gy <= n_gy;
        r_gv <= n_gv;
        for (int g = 0; g < X_GROUPS2; g++) begin
            r_hx[g] <= r_gx[GROUP*g] + r_gx[GROUP*g+1] + r_gx[GROUP*g+2] + r_gx[GROUP*g+3];
            r_hu[g] <= r_gu[GROUP*g] + r_gu[GROUP*g+1] + r_gu[GROUP*g+2] + r_gu[GROUP*g+3];
        end
        r_sy    <= r_gy[0] + r_gy[1];
        r_sv    <= r_gv[0] + r_gv[1];
        r_cl_x  <= n_cl_x;
        r_cl_y  <= n_cl_y;
        r_u4    <= f_sat32(66'(-n_su));
        r_v4    <= f_sat32(66'(-r_sv));
        r_out_x <= f_to_mm(r_cl_x);
        r_out_y <= f_to_mm(r_cl_y);
        r_out_u <= r_u4;
        r_out_v <= r_v4;
    end

    assign o_valid = r_vld[5];
    assign o_x     = r_out_x;
    assign o_y     = r_out_y;
    assign o_u     = r_out_u;
    assign o_v     = r_out_v;

endmodule

// ----- sv/beam_transport_poly_map_core.sv -----
// Top level of the third-order beam transport map.
// Depends on bt_pkg, bt_metres, bt_mono and bt_dot.
//
// Use:
//   A beat enters when start is high and busy is low. i_operation selects a
//   coefficient load (table, index, value) or a track transport (x, y, u, v,
//   delta). busy stays low: the pipeline takes one beat on every clock.
//   A transport gives one result beat, marked by o_valid for one cycle,
//   after scaling and division by 1000, then the monomials, then the
//   products, adder tree and output scaling.
//   A load gives no result; it takes effect for every track that follows it
//   and for none that came before, even with both in flight together.
//   Throughput: one beat per cycle, set by the fully pipelined multipliers.
//   Reset, synchronous and active low, empties the pipeline and clears all
//   four coefficient tables to zero; beats offered during reset are dropped.
//   The receiver cannot hold results off and must take every o_valid beat.
module beam_transport_poly_map_core import bt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [1:0]                   i_table_select,
    input  logic [IDX_WIDTH-1:0]         i_coeff_index,
    input  logic signed [COEF_WIDTH-1:0] i_coeff_value,
    input  t_word                        i_x_in,
    input  t_word                        i_y_in,
    input  t_word                        i_u_in,
    input  t_word                        i_v_in,
    input  t_word                        i_delta_in,
    output logic                         o_valid,
    output t_word                        o_x_out,
    output t_word                        o_y_out,
    output t_word                        o_u_out,
    output t_word                        o_v_out
);

    t_ctl                         w_ctl;
    t_ctl                         w_m_ctl, w_p_ctl;
    logic signed [COEF_WIDTH-1:0] w_m_coef, w_p_coef;
    t_word                        w_x, w_y, w_u, w_v, w_d;
    t_word                        w_h [HORIZ_TERMS];
    t_word                        w_t [VERT_TERMS];

    assign busy = 1'b0;

    // Wrap the beat's control fields
    always_comb begin
        w_ctl.valid = start && !busy;
        w_ctl.load  = (t_op'(i_operation) == OP_LOAD);
        w_ctl.sel   = t_tbl'(i_table_select);
        w_ctl.idx   = i_coeff_index;
    end

    bt_metres u_metres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coef  (i_coeff_value),
        .i_x     (i_x_in),
        .i_y     (i_y_in),
        .i_u     (i_u_in),
        .i_v     (i_v_in),
        .i_d     (i_delta_in),
        .o_ctl   (w_m_ctl),
        .o_coef  (w_m_coef),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_u     (w_u),
        .o_v     (w_v),
        .o_d     (w_d)
    );

    bt_mono u_mono (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_m_ctl),
        .i_coef  (w_m_coef),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_u     (w_u),
        .i_v     (w_v),
        .i_d     (w_d),
        .o_ctl   (w_p_ctl),
        .o_coef  (w_p_coef),
        .o_h     (w_h),
        .o_t     (w_t)
    );

    bt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_p_ctl),
        .i_coef  (w_p_coef),
        .i_h     (w_h),
        .i_t     (w_t),
        .o_valid (o_valid),
        .o_x     (o_x_out),
        .o_y     (o_y_out),
        .o_u     (o_u_out),
        .o_v     (o_v_out)
    );

endmodule

// ----- sv/bt_checker.sv -----
// Port-level checker for the beam transport map, bound to the top level.
// Depends on bt_pkg and beam_transport_poly_map_core_macros.svh.
`include "beam_transport_poly_map_core_macros.svh"
module bt_checker import bt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_operation,
    input logic o_valid
);

    // Each result traces back to a transport beat a fixed latency earlier
    `BT_ASSERT_IMP(a_result_has_source, o_valid, $past(start && !busy && i_operation, PIPE_LATENCY))
    // Every transport beat gives its result after the latency
    `BT_ASSERT_IMP(a_track_gives_result, start && !busy && i_operation, ##PIPE_LATENCY o_valid)
    // Loads give no result
    `BT_ASSERT_IMP(a_load_is_silent, start && !busy && !i_operation, ##PIPE_LATENCY !o_valid)
    // Reset empties the pipeline
    `BT_ASSERT_NXT(a_reset_quiet, !i_rst_n, !o_valid)

endmodule

bind beam_transport_poly_map_core bt_checker u_bt_checker (.*);

// ----- test/beam_transport_poly_map_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for beam_transport_poly_map_core: coefficient loads
// and track transports, checked against a bit-exact fixed-point predictor.
// Depends on bt_pkg and the core RTL only.
module beam_transport_poly_map_core_tb;
    import bt_pkg::*;

    typedef struct {
        t_op         op;
        t_tbl        tbl;
        logic [4:0]  idx;
        logic [39:0] coef;
        logic [31:0] x, y, u, v, d;
    } t_beat;

    typedef struct {
        logic [31:0] x, y, u, v;
    } t_track_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_operation;
    logic [1:0]        i_table_select;
    logic [4:0]        i_coeff_index;
    logic signed [39:0] i_coeff_value;
    t_word             i_x_in, i_y_in, i_u_in, i_v_in, i_delta_in;
    logic              o_valid;
    t_word             o_x_out, o_y_out, o_u_out, o_v_out;

    beam_transport_poly_map_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_table_select(i_table_select),
        .i_coeff_index(i_coeff_index), .i_coeff_value(i_coeff_value),
        .i_x_in(i_x_in), .i_y_in(i_y_in), .i_u_in(i_u_in), .i_v_in(i_v_in),
        .i_delta_in(i_delta_in), .o_valid(o_valid), .o_x_out(o_x_out),
        .o_y_out(o_y_out), .o_u_out(o_u_out), .o_v_out(o_v_out)
    );

    t_beat      pending_beats[$];
    t_track_out expected_tracks[$];
    t_beat      cur_beat;
    longint     x_tab[HORIZ_TERMS], u_tab[HORIZ_TERMS];
    longint     y_tab[VERT_TERMS], v_tab[VERT_TERMS];
    int         errors = 0, n_loads = 0, n_tracks = 0, n_results = 0;
    int         burst_left = 0, gap_left = 0, stall_cnt = 0;
    bit         stim_done = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fixed-point helpers of the predictor
    function automatic longint sat_word(longint a);
        if (a > 64'sd2147483647) return 64'sd2147483647;
        if (a < -64'sd2147483648) return -64'sd2147483648;
        return a;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return sat_word((a * b + (64'sd1 <<< 28)) >>> 29);
    endfunction

    function automatic longint coef_mul(longint c, longint m);
        logic signed [79:0] pc, pm, p;
        pc = c;
        pm = m;
        p  = (pc * pm + 80'sd8388608) >>> 24;
        return longint'(p[63:0]);
    endfunction

    function automatic longint mm_to_metres(logic [31:0] raw);
        longint n, q;
        n = -longint'($signed(raw)) * 8192 + 500;
        q = n / 1000;
        if ((n % 1000) != 0 && n < 0) q = q - 1;
        return sat_word(q);
    endfunction

    function automatic logic [31:0] metres_to_mm(longint sum);
        longint s;
        s = -sum;
        if (s > (64'sd1 <<< 40)) s = 64'sd1 <<< 40;
        if (s < -(64'sd1 <<< 40)) s = -(64'sd1 <<< 40);
        return 32'(sat_word((s * 1000 + 4096) >>> 13));
    endfunction

    // Apply a load to the tables, or work out the transported track
    task automatic predict_beat(t_beat b);
        longint x, y, u, v, d, xx, xu, xd, uu, ud, dd, sx, su, sy, sv;
        longint h[HORIZ_TERMS], t[VERT_TERMS];
        t_track_out r;
        longint c;
        c = longint'($signed(b.coef));
        if (b.op == OP_LOAD) begin
            n_loads++;
            case (b.tbl)
                TBL_X: if (b.idx < HORIZ_TERMS) x_tab[b.idx] = c;
                TBL_U: if (b.idx < HORIZ_TERMS) u_tab[b.idx] = c;
                TBL_Y: if (b.idx < VERT_TERMS) y_tab[b.idx] = c;
                default: if (b.idx < VERT_TERMS) v_tab[b.idx] = c;
            endcase
            return;
        end
        n_tracks++;
        x = mm_to_metres(b.x);
        y = mm_to_metres(b.y);
        u = sat_word(-longint'($signed(b.u)));
        v = sat_word(-longint'($signed(b.v)));
        d = longint'($signed(b.d));
        xx = q_mul(x, x); xu = q_mul(x, u); xd = q_mul(x, d);
        uu = q_mul(u, u); ud = q_mul(u, d); dd = q_mul(d, d);
        h[0] = x; h[1] = u; h[2] = d;
        h[3] = xx; h[4] = xu; h[5] = xd; h[6] = uu; h[7] = ud; h[8] = dd;
        h[9] = q_mul(y, y); h[10] = q_mul(y, v); h[11] = q_mul(v, v);
        h[12] = q_mul(xx, x); h[13] = q_mul(xx, u); h[14] = q_mul(xx, d);
        h[15] = q_mul(xu, u); h[16] = q_mul(xu, d); h[17] = q_mul(xd, d);
        h[18] = q_mul(q_mul(x, y), y); h[19] = q_mul(q_mul(x, y), v);
        h[20] = q_mul(q_mul(x, v), v);
        h[21] = q_mul(uu, u); h[22] = q_mul(uu, d); h[23] = q_mul(ud, d);
        h[24] = q_mul(q_mul(u, y), y); h[25] = q_mul(q_mul(u, y), v);
        h[26] = q_mul(q_mul(u, v), v);
        h[27] = q_mul(dd, d);
        h[28] = q_mul(q_mul(d, y), y); h[29] = q_mul(q_mul(d, y), v);
        h[30] = q_mul(q_mul(d, v), v);
        t[0] = y; t[1] = v;
        t[2] = q_mul(y, x); t[3] = q_mul(y, u); t[4] = q_mul(y, d);
        t[5] = q_mul(v, x); t[6] = q_mul(v, u); t[7] = q_mul(v, d);
        sx = 0; su = 0; sy = 0; sv = 0;
        for (int i = 0; i < HORIZ_TERMS; i++) begin
            sx += coef_mul(x_tab[i], h[i]);
            su += coef_mul(u_tab[i], h[i]);
        end
        for (int i = 0; i < VERT_TERMS; i++) begin
            sy += coef_mul(y_tab[i], t[i]);
            sv += coef_mul(v_tab[i], t[i]);
        end
        r.x = metres_to_mm(sx);
        r.y = metres_to_mm(sy);
        r.u = 32'(sat_word(-su));
        r.v = 32'(sat_word(-sv));
        expected_tracks = {expected_tracks, r};
    endtask

    // Driver: take the beat on the ports, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_beat(cur_beat);
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    start          <= 1'b1;
                    i_operation    <= cur_beat.op;
                    i_table_select <= cur_beat.tbl;
                    i_coeff_index  <= cur_beat.idx;
                    i_coeff_value  <= cur_beat.coef;
                    i_x_in         <= cur_beat.x;
                    i_y_in         <= cur_beat.y;
                    i_u_in         <= cur_beat.u;
                    i_v_in         <= cur_beat.v;
                    i_delta_in     <= cur_beat.d;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expected track
    always @(posedge i_clk) begin
        t_track_out e;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (expected_tracks.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h u=%h v=%h", $time,
                         o_x_out, o_y_out, o_u_out, o_v_out);
                errors++;
            end else begin
                e = expected_tracks.pop_front();
                if (o_x_out !== e.x) begin
                    $display("%0t: x_out expected %h actual %h", $time, e.x, o_x_out);
                    errors++;
                end
                if (o_y_out !== e.y) begin
                    $display("%0t: y_out expected %h actual %h", $time, e.y, o_y_out);
                    errors++;
                end
                if (o_u_out !== e.u) begin
                    $display("%0t: u_out expected %h actual %h", $time, e.u, o_u_out);
                    errors++;
                end
                if (o_v_out !== e.v) begin
                    $display("%0t: v_out expected %h actual %h", $time, e.v, o_v_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run after a long stretch with no beat in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) stall_cnt <= 0;
        else if (!stim_done || expected_tracks.size() > 0) stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 2000) begin
            $display("timeout waiting for beats");
            $display("beam_transport_poly_map_core_tb failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word(int mode, int small_bits);
        logic [31:0] specials[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
        if (mode == 0) return specials[$urandom_range(0, 4)];
        if (mode == 1) return $urandom();
        return 32'($signed($urandom_range(0, (1 << small_bits) - 1)) - (1 << (small_bits - 1)));
    endfunction

    function automatic logic [39:0] pick_coef(int mode);
        logic [39:0] specials[4] = '{40'h80_0000_0000, 40'h7f_ffff_ffff, 40'h0, 40'h00_0100_0000};
        if (mode == 0) return specials[$urandom_range(0, 3)];
        if (mode == 1) return 40'({$urandom(), $urandom()});
        return 40'($signed($urandom_range(0, (1 << 24) - 1)) - (1 << 23));
    endfunction

    function automatic t_beat load_beat(t_tbl tb_sel, int ix, logic [39:0] c);
        t_beat b;
        b.op = OP_LOAD; b.tbl = tb_sel; b.idx = 5'(ix); b.coef = c;
        b.x = $urandom(); b.y = $urandom(); b.u = $urandom(); b.v = $urandom();
        b.d = $urandom();
        return b;
    endfunction

    function automatic t_beat track_beat(int mode);
        t_beat b;
        b.op = OP_TRANSPORT; b.tbl = t_tbl'($urandom_range(0, 3));
        b.idx = 5'($urandom_range(0, 31)); b.coef = 40'({$urandom(), $urandom()});
        b.x = pick_word(mode, 23); b.y = pick_word(mode, 23);
        b.u = pick_word(mode, 27); b.v = pick_word(mode, 27); b.d = pick_word(mode, 27);
        return b;
    endfunction

    // Append a beat to the driver's queue
    function automatic void queue_beat(t_beat b);
        pending_beats = {pending_beats, b};
    endfunction

    // Stimulus
    initial begin
        t_beat b;
        int    m;
        foreach (x_tab[i]) begin x_tab[i] = 0; u_tab[i] = 0; end
        foreach (y_tab[i]) begin y_tab[i] = 0; v_tab[i] = 0; end
        start = 1'b0; i_operation = OP_LOAD; i_table_select = TBL_X;
        i_coeff_index = '0; i_coeff_value = '0;
        i_x_in = '0; i_y_in = '0; i_u_in = '0; i_v_in = '0; i_delta_in = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cleared tables, extreme coefficients, out-of-range indexes
        queue_beat(track_beat(1));
        queue_beat(load_beat(TBL_X, 0, 40'h00_0100_0000));
        queue_beat(load_beat(TBL_U, 1, 40'h80_0000_0000));
        queue_beat(load_beat(TBL_Y, 7, 40'h7f_ffff_ffff));
        queue_beat(load_beat(TBL_V, 0, 40'hff_ff00_0000));
        queue_beat(load_beat(TBL_X, 30, 40'h7f_ffff_ffff));
        queue_beat(load_beat(TBL_U, 30, 40'h00_0080_0000));
        queue_beat(load_beat(TBL_X, 31, 40'h12_3456_789a));
        queue_beat(load_beat(TBL_Y, 8, 40'h7f_ffff_ffff));
        queue_beat(load_beat(TBL_V, 31, 40'h80_0000_0000));
        queue_beat(load_beat(TBL_V, 1, 40'h00_0100_0000));
        for (int i = 0; i < 8; i++) queue_beat(track_beat(0));
        b = track_beat(0);
        b.x = 32'h8000_0000; b.y = 32'h8000_0000; b.u = 32'h8000_0000;
        b.v = 32'h8000_0000; b.d = 32'h8000_0000;
        queue_beat(b);
        b.x = 32'h7fff_ffff; b.y = 32'h7fff_ffff; b.u = 32'h7fff_ffff;
        b.v = 32'h7fff_ffff; b.d = 32'h7fff_ffff;
        queue_beat(b);
        queue_beat(track_beat(2));

        // Random: mostly modest tracks through modest maps, with extremes mixed in
        for (int n = 0; n < 700; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                m = $urandom_range(0, 19);
                m = (m < 3) ? 0 : (m < 8) ? 1 : 2;
                b = load_beat(t_tbl'($urandom_range(0, 3)),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 7) * 4 % 31,
                              pick_coef(m));
                if (b.tbl inside {TBL_Y, TBL_V} && b.idx > 7 && $urandom_range(0, 1))
                    b.idx = {2'b00, b.idx[2:0]};
                queue_beat(b);
            end else begin
                m = $urandom_range(0, 9);
                queue_beat(track_beat((m == 0) ? 0 : (m < 3) ? 1 : 2));
            end
        end

        // Drain: all beats offered, all tracks back, then the pipeline latency
        while (pending_beats.size() > 0 || start) @(posedge i_clk);
        stim_done = 1;
        while (expected_tracks.size() > 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d coefficient loads and %0d track transports, %0d results checked.",
                 n_loads, n_tracks, n_results);
        if (errors == 0) begin
            $display("beam_transport_poly_map_core_tb passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("beam_transport_poly_map_core_tb failed");
        end
        $finish;
    end
endmodule
